@@ hdl/smpq_pkg.sv @@
// Shared types and constants for the stable minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

    localparam int CAPACITY_DEF       = 16;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int PRIORITY_WIDTH_DEF = 8;

    localparam int ITEM_DATA_W   = 32;
    localparam int ITEM_PRIO_W   = 8;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                    operation;
        logic [ITEM_DATA_W-1:0] item_data;
        logic [ITEM_PRIO_W-1:0] item_priority;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [ITEM_DATA_W-1:0]   head_data;
        logic [ITEM_PRIO_W-1:0]   head_priority;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic start;     // input transfer this cycle
        logic shift;     // move fetched entry one slot toward the tail
        logic place;     // write the new entry at the current slot
        logic load_out;  // load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_deq;
        logic is_full;
        logic is_empty;
        logic greater;   // fetched priority above the new one
        logic left_one;  // fetched entry is the head
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/smpq_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/smpq_ctrl.sv @@
// Sequencing state machine of the priority queue.
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire smpq_pkg::t_sts  i_sts,
    output smpq_pkg::t_cmd       o_cmd
);
    import smpq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_PLACE = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.shift    = (r_state == ST_SHIFT) && i_sts.greater;
        o_cmd.place    = ((r_state == ST_SHIFT) && !i_sts.greater) || (r_state == ST_PLACE);
        o_cmd.load_out = (r_state == ST_RESP) && i_sts.out_free;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_sts.op_deq || i_sts.is_full) begin
                        n_state = ST_RESP;
                    end else if (i_sts.is_empty) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (!i_sts.greater) begin
                    n_state = ST_RESP;
                end else if (i_sts.left_one) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_no_work_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && (i_sts.op_deq || i_sts.is_full)) |=> (r_state == ST_RESP))
        else $error("dequeue or rejected enqueue did not go straight to response");
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_in_ready)
        else $error("not ready after result load");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
`endif

endmodule

`default_nettype wire

@@ hdl/smpq_dp.sv @@
// Datapath: circular sorted entry store, pointers, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module smpq_dp #(
    parameter int CAPACITY       = smpq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH     = smpq_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = smpq_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire smpq_pkg::t_in_item  i_in_item,
    input  wire smpq_pkg::t_cmd      i_cmd,
    output smpq_pkg::t_sts           o_sts,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output smpq_pkg::t_out_item      o_out_item
);
    import smpq_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int WORD_W  = DATA_WIDTH + PRIORITY_WIDTH;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(CAPACITY - 1)) ? '0 : x + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
        return (x == '0) ? IDX_W'(CAPACITY - 1) : x - IDX_W'(1);
    endfunction

    logic [IDX_W-1:0]          r_head, n_head;
    logic [IDX_W-1:0]          r_tail, n_tail;
    logic [IDX_W-1:0]          r_ptr, n_ptr;
    logic [IDX_W-1:0]          r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic [COUNT_W-1:0]        r_left, n_left;
    logic [DATA_WIDTH-1:0]     r_new_data, n_new_data;
    logic [PRIORITY_WIDTH-1:0] r_new_prio, n_new_prio;
    t_status                   r_status, n_status;
    logic                      r_take_head, n_take_head;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [WORD_W-1:0]         ram_rdata;

    logic [DATA_WIDTH-1:0]     rd_data;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic                      op_deq;
    logic                      is_full;
    logic                      is_empty;

    assign rd_data  = ram_rdata[DATA_WIDTH-1:0];
    assign rd_prio  = ram_rdata[WORD_W-1 -: PRIORITY_WIDTH];
    assign op_deq   = (i_in_item.operation == OP_DEQUEUE);
    assign is_full  = (r_count == COUNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    always_comb begin
        o_sts          = '0;
        o_sts.op_deq   = op_deq;
        o_sts.is_full  = is_full;
        o_sts.is_empty = is_empty;
        o_sts.greater  = rd_prio > r_new_prio;
        o_sts.left_one = (r_left == COUNT_W'(1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // store port control; no fetch past the head on the last shift
    assign ram_re    = (i_cmd.start && !is_empty && (op_deq || !is_full))
                       || (i_cmd.shift && (r_left != COUNT_W'(1)));
    assign ram_raddr = i_cmd.shift ? idx_dec(r_rd_ptr) : (op_deq ? r_head : idx_dec(r_tail));
    assign ram_we    = i_cmd.shift || i_cmd.place;
    assign ram_waddr = r_ptr;
    assign ram_wdata = i_cmd.shift ? ram_rdata : {r_new_prio, r_new_data};

    smpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_ptr       = r_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_left      = r_left;
        n_new_data  = r_new_data;
        n_new_prio  = r_new_prio;
        n_status    = r_status;
        n_take_head = r_take_head;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cmd.start) begin
            n_new_data  = DATA_WIDTH'(i_in_item.item_data);
            n_new_prio  = PRIORITY_WIDTH'(i_in_item.item_priority);
            n_take_head = 1'b0;
            n_status    = STATUS_DONE;
            if (op_deq) begin
                if (is_empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    n_take_head = 1'b1;
                    n_head      = idx_inc(r_head);
                    n_count     = r_count - COUNT_W'(1);
                end
            end else begin
                if (is_full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_count  = r_count + COUNT_W'(1);
                    n_tail   = idx_inc(r_tail);
                    n_ptr    = r_tail;
                    n_rd_ptr = idx_dec(r_tail);
                    n_left   = r_count;
                end
            end
        end

        if (i_cmd.shift) begin
            n_ptr    = r_rd_ptr;
            n_rd_ptr = idx_dec(r_rd_ptr);
            n_left   = r_left - COUNT_W'(1);
        end

        if (i_cmd.load_out) begin
            n_out.status        = r_status;
            n_out.head_data     = r_take_head ? ITEM_DATA_W'(rd_data) : '0;
            n_out.head_priority = r_take_head ? ITEM_PRIO_W'(rd_prio) : '0;
            n_out.entry_count   = ENTRY_COUNT_W'(r_count);
            n_out_valid         = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_rd_ptr    <= n_rd_ptr;
        r_left      <= n_left;
        r_new_data  <= n_new_data;
        r_new_prio  <= n_new_prio;
        r_status    <= n_status;
        r_take_head <= n_take_head;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_ptr_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_tail >= r_head) ? (COUNT_W'(r_tail) - COUNT_W'(r_head))
            : (COUNT_W'(r_tail) + COUNT_W'(CAPACITY) - COUNT_W'(r_head)))
        == ((r_count == COUNT_W'(CAPACITY)) ? '0 : r_count))
        else $error("head/tail span disagrees with entry count");
    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store read and write at the same slot");
`endif

endmodule

`default_nettype wire

@@ hdl/stable_min_priority_queue_unit.sv @@
// Top level of the stable minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to CAPACITY entries (data word and priority) sorted by ascending
// priority in a circular RAM, equal priorities in arrival order. Each input
// transfer gives exactly one result transfer with status and entry count.
// One item is worked at a time; input is ready again once the result is
// loaded. Dequeue, dequeue on empty and enqueue on full go from the input
// transfer straight to the response state; an enqueue first moves each held
// entry with a higher priority number one slot toward the tail, one per
// cycle through the store's one read port and one write port, and then
// writes the new entry. No clearing pass is needed after reset.

module stable_min_priority_queue_unit #(
    parameter int CAPACITY       = smpq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH     = smpq_pkg::DATA_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = smpq_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire smpq_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output smpq_pkg::t_out_item      o_out_item
);
    import smpq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smpq_dp #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ tb/stable_min_priority_queue_unit_tb.sv @@
// Self-checking testbench for the stable minimum priority queue unit.
`timescale 1ns / 1ps

module stable_min_priority_queue_unit_tb;
    import smpq_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int DRAIN_CYCLES = 30;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    logic [ITEM_DATA_W-1:0] held_data [CAP];
    logic [ITEM_PRIO_W-1:0] held_prio [CAP];
    int                     held_count;
    t_out_item              pending_results [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;
    int hold_left;
    int fail_count;
    int cycle_count;

    stable_min_priority_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // sorted insert after equal priorities, head removal on dequeue
    function automatic t_out_item apply_queue_op(t_in_item it);
        t_out_item res;
        int        slot;
        int        i;
        res = '0;
        res.status = STATUS_DONE;
        if (it.operation == OP_ENQUEUE) begin
            if (held_count >= CAP) begin
                res.status = STATUS_FULL;
            end else begin
                slot = 0;
                while (slot < held_count && held_prio[slot] <= it.item_priority) slot++;
                for (i = held_count; i > slot; i--) begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[slot] = it.item_data;
                held_prio[slot] = it.item_priority;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.head_data     = held_data[0];
            res.head_priority = held_prio[0];
            for (i = 1; i < held_count; i++) begin
                held_data[i-1] = held_data[i];
                held_prio[i-1] = held_prio[i];
            end
            held_count--;
        end
        res.entry_count = ENTRY_COUNT_W'(held_count);
        return res;
    endfunction

    function automatic t_in_item make_item(t_op op, logic [ITEM_DATA_W-1:0] data,
                                           logic [ITEM_PRIO_W-1:0] prio);
        t_in_item it;
        it.operation     = op;
        it.item_data     = data;
        it.item_priority = prio;
        return it;
    endfunction

    // mostly narrow bands so that ties are common
    function automatic logic [ITEM_PRIO_W-1:0] rand_priority();
        logic [ITEM_PRIO_W-1:0] p;
        case ($urandom_range(3))
            0: p = ITEM_PRIO_W'($urandom_range(3));
            1: p = ITEM_PRIO_W'($urandom_range(255));
            2: p = $urandom_range(1) ? '1 : '0;
            default: p = ITEM_PRIO_W'($urandom_range(103, 100));
        endcase
        return p;
    endfunction

    function automatic logic [ITEM_DATA_W-1:0] rand_data();
        logic [ITEM_DATA_W-1:0] d;
        case ($urandom_range(7))
            0: d = '0;
            1: d = '1;
            default: d = ITEM_DATA_W'($urandom);
        endcase
        return d;
    endfunction

    task automatic send_op(t_in_item it);
        @(negedge i_clk);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        pending_results.push_back(apply_queue_op(it));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_op(make_item(OP_DEQUEUE, '0, '0));
        send_op(make_item(OP_ENQUEUE, '0, '1));
        send_op(make_item(OP_ENQUEUE, '1, '0));
        send_op(make_item(OP_ENQUEUE, 32'hA5A5_A5A5, 8'd7));
        send_op(make_item(OP_ENQUEUE, 32'h5A5A_5A5A, 8'd7));
        send_op(make_item(OP_ENQUEUE, 32'h0000_FFFF, 8'd7));
        send_op(make_item(OP_ENQUEUE, 32'hFFFF_0000, 8'd0));
        repeat (6) send_op(make_item(OP_DEQUEUE, '1, '1));
        send_op(make_item(OP_DEQUEUE, '1, '1));
        wait_drained();
    endtask

    task automatic test_fill_and_drain();
        while (held_count < CAP) send_op(make_item(OP_ENQUEUE, rand_data(), rand_priority()));
        repeat (2) send_op(make_item(OP_ENQUEUE, rand_data(), rand_priority()));
        while (held_count > 0) send_op(make_item(OP_DEQUEUE, rand_data(), rand_priority()));
        send_op(make_item(OP_DEQUEUE, rand_data(), rand_priority()));
    endtask

    task automatic test_random_traffic(int n_items);
        int enq_pct;
        t_op op;
        enq_pct = 75;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 39) enq_pct = 100 - enq_pct;
            op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            send_op(make_item(op, rand_data(), rand_priority()));
        end
    endtask

    // receiver holds off while descending priorities force the longest inserts
    task automatic test_backpressure_hold();
        wait_drained();
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++)
            send_op(make_item(OP_ENQUEUE, rand_data(), ITEM_PRIO_W'(200 - k)));
        repeat (12) send_op(make_item(OP_DEQUEUE, rand_data(), rand_priority()));
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation pending: %p", out_item);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_item.status);
                    fail_count++;
                end
                if (out_item.head_data !== want.head_data) begin
                    $error("head_data: expected %h, actual %h",
                           want.head_data, out_item.head_data);
                    fail_count++;
                end
                if (out_item.head_priority !== want.head_priority) begin
                    $error("head_priority: expected %0d, actual %0d",
                           want.head_priority, out_item.head_priority);
                    fail_count++;
                end
                if (out_item.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, out_item.entry_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int idle_set  [4];
        int stall_set [4];
        idle_set  = '{0, 70, 0, 17};
        stall_set = '{0, 0, 70, 17};
        i_rst_n            = 1'b0;
        in_valid           = 1'b0;
        in_item            = '0;
        out_ready          = 1'b0;
        held_count         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        hold_left          = 0;
        fail_count         = 0;
        cycle_count        = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = idle_set[ph];
            receiver_stall_pct = stall_set[ph];
            test_random_traffic(240);
            test_fill_and_drain();
            wait_drained();
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_backpressure_hold();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/smpq_pkg.sv
hdl/smpq_ram.sv
hdl/smpq_ctrl.sv
hdl/smpq_dp.sv
hdl/stable_min_priority_queue_unit.sv
tb/stable_min_priority_queue_unit_tb.sv
